// File: src/pbl_pkg.sv
// Package for the page buffer lookup: sizes, field widths and queue entry type.
package pbl_pkg;

   localparam int SlotCount    = 8;
   localparam int PageBytes    = 4096;
   localparam int AddressBits  = 32;
   localparam int UseCountBits = 16;

   localparam int SlotBits   = (SlotCount > 1) ? $clog2(SlotCount) : 1;

   localparam int QueueDepth = 2;

   typedef logic [AddressBits-1:0] addr_type;

   // One classified request travelling from the front part to the back part.
   typedef struct packed {
      logic     past_end;
      addr_type address;
   } job_type;

endpackage

// File: src/pbl_front.sv
// Front part: takes request beats, checks them against the store size and queues them.
module pbl_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [31:0]        req_byte_address,
   input  logic [31:0]        store_size,
   output logic               job_valid,
   input  logic               job_take,
   output pbl_pkg::job_type   job
);
   import pbl_pkg::*;

   job_type          queue_ff [QueueDepth];
   logic             head_ff, head_in;
   logic             tail_ff, tail_in;
   logic [1:0]       count_ff, count_in;
   logic             push;
   job_type          entry;

   assign req_stall = (count_ff == 2'(QueueDepth));
   assign push      = req_valid && !req_stall;
   assign job_valid = (count_ff != 2'd0);
   assign job       = queue_ff[head_ff];

   always_comb begin
      entry.address  = req_byte_address[AddressBits-1:0];
      entry.past_end = ({32'd0, entry.address} >= {32'd0, store_size});
      head_in  = head_ff + ((job_take && job_valid) ? 1'b1 : 1'b0);
      tail_in  = tail_ff + (push ? 1'b1 : 1'b0);
      count_in = count_ff + (push ? 2'd1 : 2'd0) - ((job_take && job_valid) ? 2'd1 : 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= 1'b0;
         tail_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[tail_ff] <= entry;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(QueueDepth)) else $error("queue overflow");
   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (push && !(job_take && job_valid)) |=> count_ff == $past(count_ff) + 2'd1)
      else $error("count did not rise on push");
   a_empty_stall: assert property (@(posedge clock) disable iff (reset)
      !job_valid |-> !req_stall) else $error("stall while empty");
`endif
endmodule

// File: src/pbl_back.sv
// Back part: slot directory lookup, victim choice, state update and result register.
module pbl_back (
   input  logic               clock,
   input  logic               reset,
   input  logic [31:0]        store_size,
   input  logic               job_valid,
   output logic               job_take,
   input  pbl_pkg::job_type   job,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_past_end,
   output logic               rsp_hit,
   output logic [2:0]         rsp_slot_index,
   output logic [11:0]        rsp_page_offset,
   output logic               rsp_writeback_valid,
   output logic [31:0]        rsp_writeback_base,
   output logic [12:0]        rsp_writeback_length,
   output logic               rsp_fill_valid,
   output logic [31:0]        rsp_fill_base,
   output logic [12:0]        rsp_fill_length
);
   import pbl_pkg::*;

   localparam logic [UseCountBits-1:0] UseMax = '1;

   logic [SlotCount-1:0]    valid_ff;
   addr_type                base_ff  [SlotCount];
   addr_type                end_ff   [SlotCount];
   logic [UseCountBits-1:0] use_ff   [SlotCount];

   logic                    out_valid_ff;
   logic                    o_oor_ff, o_hit_ff, o_wbv_ff, o_flv_ff;
   logic [2:0]              o_slot_ff;
   logic [11:0]             o_off_ff;
   logic [31:0]             o_wbb_ff, o_flb_ff;
   logic [12:0]             o_wbl_ff, o_fll_ff;

   logic                    found, free_found;
   logic [SlotBits-1:0]     hit_slot, free_slot, lfu_slot, sel;
   addr_type                page_base, page_last, size_last, wb_len_full, fl_len_full;
   addr_type                sel_base;
   logic                    do_update;

   assign job_take  = job_valid && (!out_valid_ff || !rsp_stall);
   assign do_update = job_take && !job.past_end;

   always_comb begin
      found      = 1'b0;
      free_found = 1'b0;
      hit_slot   = '0;
      free_slot  = '0;
      lfu_slot   = '0;
      for (int i = SlotCount - 1; i >= 0; i--) begin
         if (valid_ff[i] && base_ff[i] <= job.address && job.address <= end_ff[i]) begin
            found    = 1'b1;
            hit_slot = SlotBits'(i);
         end
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_slot  = SlotBits'(i);
         end
      end
      for (int i = 1; i < SlotCount; i++) begin
         if (use_ff[i] < use_ff[lfu_slot]) begin
            lfu_slot = SlotBits'(i);
         end
      end
      sel       = found ? hit_slot : (free_found ? free_slot : lfu_slot);
      page_base = job.address & ~addr_type'(PageBytes - 1);
      size_last = addr_type'({32'd0, store_size} - 64'd1);
      if (size_last - page_base < addr_type'(PageBytes - 1)) begin
         page_last = size_last;
      end else begin
         page_last = page_base + addr_type'(PageBytes - 1);
      end
      wb_len_full = end_ff[sel] - base_ff[sel] + addr_type'(1);
      fl_len_full = page_last - page_base + addr_type'(1);
      sel_base    = found ? base_ff[sel] : page_base;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         for (int i = 0; i < SlotCount; i++) begin
            base_ff[i] <= '0;
            end_ff[i]  <= '0;
            use_ff[i]  <= '0;
         end
      end else if (do_update) begin
         if (found) begin
            if (use_ff[sel] != UseMax) begin
               use_ff[sel] <= use_ff[sel] + 1'b1;
            end
         end else begin
            valid_ff[sel] <= 1'b1;
            base_ff[sel]  <= page_base;
            end_ff[sel]   <= page_last;
            use_ff[sel]   <= UseCountBits'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (job_take) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (job_take) begin
         o_oor_ff  <= job.past_end;
         o_hit_ff  <= !job.past_end && found;
         o_slot_ff <= job.past_end ? 3'd0 : 3'(sel);
         o_off_ff  <= job.past_end ? 12'd0 : 12'(job.address - sel_base);
         o_wbv_ff  <= !job.past_end && !found && !free_found;
         o_wbb_ff  <= (!job.past_end && !found && !free_found) ? 32'(base_ff[sel]) : 32'd0;
         o_wbl_ff  <= (!job.past_end && !found && !free_found) ? 13'(wb_len_full) : 13'd0;
         o_flv_ff  <= !job.past_end && !found;
         o_flb_ff  <= (!job.past_end && !found) ? 32'(page_base) : 32'd0;
         o_fll_ff  <= (!job.past_end && !found) ? 13'(fl_len_full) : 13'd0;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_past_end         = o_oor_ff;
   assign rsp_hit              = o_hit_ff;
   assign rsp_slot_index       = o_slot_ff;
   assign rsp_page_offset      = o_off_ff;
   assign rsp_writeback_valid  = o_wbv_ff;
   assign rsp_writeback_base   = o_wbb_ff;
   assign rsp_writeback_length = o_wbl_ff;
   assign rsp_fill_valid       = o_flv_ff;
   assign rsp_fill_base        = o_flb_ff;
   assign rsp_fill_length      = o_fll_ff;

`ifndef SYNTHESIS
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !job_take)
      else $error("result overwritten while stalled");
   a_fill_valid_slot: assert property (@(posedge clock) disable iff (reset)
      (do_update && !found) |=> valid_ff[$past(sel)]) else $error("fill left slot invalid");
   a_hit_no_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_hit && rsp_fill_valid)) else $error("hit with fill");
   a_wb_needs_fill: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_writeback_valid) |-> rsp_fill_valid) else $error("orphan write-back");
`endif
endmodule

// File: src/page_buffer_lookup_lfu_top.sv
// Top level of the page buffer lookup with least-frequently-used replacement.
// Each request beat is checked against the store size in the front part and queued in a
// two-entry queue; the back part looks the address up in eight slots, picks a free or
// least-used slot on a miss, updates the directory and registers one result beat. The back
// part takes a new item when its result register is empty or being read, so one beat per
// cycle is sustained while the result side takes beats. A request is held in the queue, then
// in the result register. The csr_ channel, which is always ready, writes the store size.
module page_buffer_lookup_lfu_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_byte_address,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_past_end,
   output logic        rsp_hit,
   output logic [2:0]  rsp_slot_index,
   output logic [11:0] rsp_page_offset,
   output logic        rsp_writeback_valid,
   output logic [31:0] rsp_writeback_base,
   output logic [12:0] rsp_writeback_length,
   output logic        rsp_fill_valid,
   output logic [31:0] rsp_fill_base,
   output logic [12:0] rsp_fill_length
);
   import pbl_pkg::*;

   logic [31:0] size_ff;
   logic        job_valid, job_take;
   job_type     job;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= '0;
      end else if (csr_valid) begin
         size_ff <= csr_data;
      end
   end

   pbl_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_byte_address,
      .store_size(size_ff), .job_valid, .job_take, .job
   );

   pbl_back u_back (
      .clock, .reset, .store_size(size_ff), .job_valid, .job_take, .job,
      .rsp_valid, .rsp_stall, .rsp_past_end, .rsp_hit, .rsp_slot_index,
      .rsp_page_offset, .rsp_writeback_valid, .rsp_writeback_base,
      .rsp_writeback_length, .rsp_fill_valid, .rsp_fill_base, .rsp_fill_length
   );
endmodule

// File: tb/tb.sv
// Self-checking testbench for the page buffer lookup with least-frequently-used replacement.
module tb;
   import pbl_pkg::*;

   typedef struct {
      logic        past_end;
      logic        hit;
      logic [2:0]  slot_index;
      logic [11:0] page_offset;
      logic        writeback_valid;
      logic [31:0] writeback_base;
      logic [12:0] writeback_length;
      logic        fill_valid;
      logic [31:0] fill_base;
      logic [12:0] fill_length;
   } lookup_result_type;

   logic        clock;
   logic        reset;
   logic        csr_valid;
   logic        csr_ready;
   logic [31:0] csr_data;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_byte_address;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_past_end;
   logic        rsp_hit;
   logic [2:0]  rsp_slot_index;
   logic [11:0] rsp_page_offset;
   logic        rsp_writeback_valid;
   logic [31:0] rsp_writeback_base;
   logic [12:0] rsp_writeback_length;
   logic        rsp_fill_valid;
   logic [31:0] rsp_fill_base;
   logic [12:0] rsp_fill_length;

   page_buffer_lookup_lfu_top dut (.*);

   // Predictor copy of the slot directory.
   logic        dir_valid [SlotCount];
   logic [31:0] dir_base  [SlotCount];
   logic [31:0] dir_last  [SlotCount];
   logic [15:0] dir_uses  [SlotCount];
   logic [31:0] cur_store_size;

   logic [31:0]       pending_addresses [$];
   lookup_result_type expected_lookups [$];
   int                mismatch_count;
   int                accepted_count;
   bit                idle_free;
   bit                hold_off;
   bit                hold_phase;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50000000;
      $display("FAIL");
      $finish;
   end

   // The result side holds off for a long stretch once the hold-off phase starts.
   initial begin
      hold_off = 0;
      wait (hold_phase);
      hold_off = 1;
      repeat (60) @(posedge clock);
      hold_off = 0;
   end

   function automatic lookup_result_type predict_lookup(logic [31:0] addr);
      lookup_result_type r;
      int s;
      int best;
      logic [31:0] last;
      r = '{default: '0};
      if (addr >= cur_store_size) begin
         r.past_end = 1;
         return r;
      end
      s = -1;
      for (int i = 0; i < SlotCount; i++)
         if (s < 0 && dir_valid[i] && dir_base[i] <= addr && addr <= dir_last[i]) s = i;
      if (s >= 0) begin
         r.hit = 1;
         if (dir_uses[s] != 16'hFFFF) dir_uses[s]++;
      end else begin
         best = -1;
         for (int i = 0; i < SlotCount; i++)
            if (best < 0 && !dir_valid[i]) best = i;
         if (best < 0) begin
            best = 0;
            for (int i = 1; i < SlotCount; i++)
               if (dir_uses[i] < dir_uses[best]) best = i;
            r.writeback_valid  = 1;
            r.writeback_base   = dir_base[best];
            r.writeback_length = 13'(dir_last[best] - dir_base[best] + 1);
         end
         s = best;
         dir_base[s] = {addr[31:12], 12'b0};
         if (cur_store_size - 1 - dir_base[s] < PageBytes - 1) last = cur_store_size - 1;
         else last = dir_base[s] + PageBytes - 1;
         dir_last[s]  = last;
         dir_valid[s] = 1;
         dir_uses[s]  = 1;
         r.fill_valid  = 1;
         r.fill_base   = dir_base[s];
         r.fill_length = 13'(last - dir_base[s] + 1);
      end
      r.slot_index  = 3'(s);
      r.page_offset = 12'(addr - dir_base[s]);
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      mismatch_count++;
   endtask

   // Driver: one request beat per accepted item, with random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
         req_byte_address <= '0;
      end else begin
         if (req_valid && !req_stall) begin
            accepted_count++;
            expected_lookups.push_back(predict_lookup(req_byte_address));
         end
         if (!req_valid || !req_stall) begin
            if (pending_addresses.size() > 0 && (idle_free || $urandom_range(99) >= 10)) begin
               req_valid <= 1;
               req_byte_address <= pending_addresses.pop_front();
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   // Monitor: checks every result beat and stalls at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_lookups.size() == 0) begin
               report_mismatch("unexpected beat", '0, '0);
            end else begin
               lookup_result_type e;
               e = expected_lookups.pop_front();
               if (rsp_past_end !== e.past_end)
                  report_mismatch("past_end", 32'(rsp_past_end), 32'(e.past_end));
               if (rsp_hit !== e.hit) report_mismatch("hit", 32'(rsp_hit), 32'(e.hit));
               if (rsp_slot_index !== e.slot_index)
                  report_mismatch("slot_index", 32'(rsp_slot_index), 32'(e.slot_index));
               if (rsp_page_offset !== e.page_offset)
                  report_mismatch("page_offset", 32'(rsp_page_offset), 32'(e.page_offset));
               if (rsp_writeback_valid !== e.writeback_valid)
                  report_mismatch("writeback_valid", 32'(rsp_writeback_valid),
                                  32'(e.writeback_valid));
               if (rsp_writeback_base !== e.writeback_base)
                  report_mismatch("writeback_base", rsp_writeback_base, e.writeback_base);
               if (rsp_writeback_length !== e.writeback_length)
                  report_mismatch("writeback_length", 32'(rsp_writeback_length),
                                  32'(e.writeback_length));
               if (rsp_fill_valid !== e.fill_valid)
                  report_mismatch("fill_valid", 32'(rsp_fill_valid), 32'(e.fill_valid));
               if (rsp_fill_base !== e.fill_base)
                  report_mismatch("fill_base", rsp_fill_base, e.fill_base);
               if (rsp_fill_length !== e.fill_length)
                  report_mismatch("fill_length", 32'(rsp_fill_length), 32'(e.fill_length));
            end
         end
         rsp_stall <= hold_off || (!idle_free && $urandom_range(99) < 10);
      end
   end

   task automatic write_store_size(logic [31:0] value);
      @(posedge clock);
      csr_valid <= 1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      cur_store_size = value;
      csr_valid <= 0;
   endtask

   task automatic wait_drained();
      while (pending_addresses.size() > 0 || req_valid || expected_lookups.size() > 0)
         @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   // Mostly addresses near a few hot pages so that hits and evictions both occur.
   function automatic logic [31:0] pick_address(logic [31:0] size);
      int k;
      k = $urandom_range(99);
      if (size == 0 || k < 8) return $urandom();
      if (k < 15) return size - 1 - $urandom_range(3);
      if (k < 20) return size + $urandom_range(3);
      if (size > 32'h10000 && k < 85)
         return {4'($urandom_range(11)), 16'h0, 12'($urandom())} % size;
      return $urandom() % size;
   endfunction

   initial begin
      logic [31:0] sizes [6];
      sizes = '{32'h0000_C800, 32'hFFFF_FFFF, 32'h0000_1001, 32'h0000_0001,
                32'h2345_6789, 32'h8000_0000};
      csr_valid = 0;
      csr_data = 0;
      mismatch_count = 0;
      accepted_count = 0;
      idle_free = 0;
      cur_store_size = 0;
      for (int i = 0; i < SlotCount; i++) begin
         dir_valid[i] = 0;
         dir_base[i] = 0;
         dir_last[i] = 0;
         dir_uses[i] = 0;
      end
      reset = 1;
      repeat (7) @(posedge clock);
      reset <= 0;

      // Size zero: everything is out of range.
      pending_addresses.push_back(0);
      pending_addresses.push_back(32'hFFFF_FFFF);
      wait_drained();

      // Directed: partial last page, hits, ten pages to force evictions.
      write_store_size(32'h0000_C800);
      for (int p = 0; p < 10; p++) pending_addresses.push_back(p * 4096 + p);
      pending_addresses.push_back(32'h0000_C7FF);
      pending_addresses.push_back(32'h0000_C800);
      pending_addresses.push_back(32'h0000_0FFF);
      pending_addresses.push_back(32'h0000_9000);
      pending_addresses.push_back(32'hFFFF_FFFF);
      wait_drained();
      // Shrinking the store leaves stale slots that may still hit.
      write_store_size(32'h0000_2000);
      pending_addresses.push_back(32'h0000_1FFF);
      pending_addresses.push_back(32'h0000_0000);
      pending_addresses.push_back(32'h0000_3000);
      wait_drained();

      // Long hold-off on the result side while requests keep coming.
      write_store_size(32'hFFFF_FFFF);
      hold_phase = 1;
      for (int i = 0; i < 40; i++) pending_addresses.push_back(pick_address(cur_store_size));
      wait_drained();

      // A run of back-to-back hits on one page.
      idle_free = 1;
      for (int i = 0; i < 100; i++) pending_addresses.push_back(32'h0000_0010);
      wait_drained();
      idle_free = 0;

      for (int ph = 0; ph < 6; ph++) begin
         write_store_size(sizes[ph]);
         idle_free = (ph == 2);
         for (int i = 0; i < 220; i++) pending_addresses.push_back(pick_address(sizes[ph]));
         wait_drained();
      end
      idle_free = 0;
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && expected_lookups.size() == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end
endmodule
